// File: hdl/cppc_pkg.sv
// Package of the cassette port pulse codec: shared types, codes and constants.
// Depends on nothing; imported by cppc_dp, cppc_ctrl and the top.
`timescale 1ns / 1ps

package cppc_pkg;

	// Operation codes of an input beat.
	localparam logic [1:0] FUNC_WRITE = 2'd0;
	localparam logic [1:0] FUNC_READ  = 2'd1;
	localparam logic [1:0] FUNC_PUSH  = 2'd2;

	// Deck button positions.
	localparam logic [1:0] DECK_STOP   = 2'd0;
	localparam logic [1:0] DECK_PLAY   = 2'd1;
	localparam logic [1:0] DECK_RECORD = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] REG_DECK_MODE   = 2'd0;
	localparam logic [1:0] REG_SHORT       = 2'd1;
	localparam logic [1:0] REG_LONG        = 2'd2;
	localparam logic [1:0] REG_THRESHOLD   = 2'd3;

	// Reset values of the configuration registers.
	localparam logic [15:0] SHORT_PERIOD_RST = 16'd56;
	localparam logic [15:0] LONG_PERIOD_RST  = 16'd112;
	localparam logic [15:0] THRESHOLD_RST    = 16'd32;

	// Bit positions in a written port byte.
	localparam int PORT_MOTOR_BIT = 1;
	localparam int PORT_REC_BIT   = 0;

	// Read byte pieces.
	localparam logic [7:0] READ_BASE      = 8'h1f;
	localparam logic [7:0] READ_TAPE_HIGH = 8'h80;
	localparam logic [7:0] READ_MOTOR_OFF = 8'h40;

	// Playback symbol codes.
	typedef logic [1:0] sym_t;
	localparam sym_t SYM_NONE = 2'd0;
	localparam sym_t SYM_ZERO = 2'd1;
	localparam sym_t SYM_ONE  = 2'd2;
	localparam sym_t SYM_END  = 2'd3;

	// One result beat.
	typedef struct packed {
		logic       read_valid;
		logic [7:0] read_data;
		logic       rec_valid;
		logic       rec_bit;
		logic       push_dropped;
	} result_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;   // take the input beat
		logic exec;      // carry out the operation of the held beat
		logic check;     // compare the tape position with the end of the symbol
		logic pop;       // fetch the next symbol from the FIFO
		logic level;     // work out the tape level for the read byte
		logic load_out;  // move the result into the output register
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic tape_read;   // held beat is a read that must follow the tape
		logic more;        // tape position has reached the end of the symbol
		logic fifo_empty;
		logic out_free;    // output register can take a result this cycle
	} dp_stat_t;

endpackage

// File: hdl/cppc_if.sv
// Channel interfaces of the cassette port pulse codec: input and result beats.
// Depends on nothing.
`timescale 1ns / 1ps

interface cppc_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [31:0] now;
	logic [7:0]  port_value;
	logic        tape_symbol;

	modport source (output valid, func, now, port_value, tape_symbol, input ready);
	modport sink (input valid, func, now, port_value, tape_symbol, output ready);
endinterface

interface cppc_out_if;
	logic       valid;
	logic       ready;
	logic       read_valid;
	logic [7:0] read_data;
	logic       rec_valid;
	logic       rec_bit;
	logic       push_dropped;

	modport source (output valid, read_valid, read_data, rec_valid, rec_bit, push_dropped,
		input ready);
	modport sink (input valid, read_valid, read_data, rec_valid, rec_bit, push_dropped,
		output ready);
endinterface

// File: hdl/cassette_port_pulse_codec_top.sv
// Channel       | Direction | Beat contents
// in_ch         | sink      | func, now, port_value, tape_symbol
// out_ch        | source    | read_valid, read_data, rec_valid, rec_bit, push_dropped
// cfg_*         | write     | cfg_index selects the register, cfg_wdata the value
//
// A write, a push or a read without playback runs EXEC and then EMIT after accept.
// A playback read: EXEC, CHECK and POP per popped symbol, then CHECK, LEVEL and EMIT;
// each symbol costs one compare step and one registered FIFO read in the datapath.
// Asynchronous active-low reset; the FIFO memory itself is not cleared.
// A new beat is accepted while an earlier result waits in the output register;
// the controller stalls only if a second result is ready before the first is taken.
`timescale 1ns / 1ps

module cassette_port_pulse_codec_top
	import cppc_pkg::*;
#(
	parameter int TAPE_FIFO_DEPTH = 16,
	parameter int TIME_WIDTH      = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_wdata,
	cppc_in_if.sink     in_ch,
	cppc_out_if.source  out_ch
);

	dp_cmd_t  cmd;
	dp_stat_t stat;
	result_t  out_data;

	cppc_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_ch.valid),
		.in_ready(in_ch.ready),
		.stat    (stat),
		.cmd     (cmd)
	);

	cppc_dp #(
		.TAPE_FIFO_DEPTH(TAPE_FIFO_DEPTH),
		.TIME_WIDTH     (TIME_WIDTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.func       (in_ch.func),
		.now        (in_ch.now),
		.port_value (in_ch.port_value),
		.tape_symbol(in_ch.tape_symbol),
		.cmd        (cmd),
		.stat       (stat),
		.out_ready  (out_ch.ready),
		.out_valid  (out_ch.valid),
		.out_data   (out_data)
	);

	assign out_ch.read_valid   = out_data.read_valid;
	assign out_ch.read_data    = out_data.read_data;
	assign out_ch.rec_valid    = out_data.rec_valid;
	assign out_ch.rec_bit      = out_data.rec_bit;
	assign out_ch.push_dropped = out_data.push_dropped;

	// A result is never loaded over one that is still waiting.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_ch.valid || out_ch.ready))
		else $error("output register overwritten while a result waits");

	// A symbol is only fetched from a FIFO that holds one.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> !stat.fifo_empty)
		else $error("pop from an empty tape FIFO");

	// A result answers at most one kind of operation.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> ($countones({out_ch.read_valid, out_ch.rec_valid,
			out_ch.push_dropped}) <= 1))
		else $error("result flags more than one operation");

	// Only one beat is in the datapath at a time.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |=> !in_ch.ready)
		else $error("second beat accepted while one is in progress");

endmodule

// File: hdl/cppc_fifo.sv
// Tape symbol FIFO of the cassette port pulse codec: one-bit memory, registered read.
// Standalone; used by cppc_dp.
`timescale 1ns / 1ps

module cppc_fifo #(
	parameter int DEPTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  logic push_data,
	input  logic pop,
	output logic empty,
	output logic full,
	output logic rd_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	logic          mem [DEPTH];
	logic [AW-1:0] head_q;
	logic [AW-1:0] tail_q;
	logic [CW-1:0] count_q;
	logic          rd_data_q;

	assign empty   = (count_q == '0);
	assign full    = (count_q == CW'(DEPTH));
	assign rd_data = rd_data_q;

	// Storage: written at the tail, the head entry is read every cycle.
	always_ff @(posedge clk) begin
		if (push) begin
			mem[tail_q] <= push_data;
		end
		rd_data_q <= mem[head_q];
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				tail_q <= (tail_q == LAST) ? '0 : tail_q + 1'b1;
			end
			if (pop) begin
				head_q <= (head_q == LAST) ? '0 : head_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: hdl/cppc_dp.sv
// Datapath of the cassette port pulse codec: configuration, motor, record and
// playback state, the tape FIFO and the output register. Depends on cppc_pkg, cppc_fifo.
`timescale 1ns / 1ps

module cppc_dp
	import cppc_pkg::*;
#(
	parameter int TAPE_FIFO_DEPTH = 16,
	parameter int TIME_WIDTH      = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_wdata,
	input  logic [1:0]  func,
	input  logic [31:0] now,
	input  logic [7:0]  port_value,
	input  logic        tape_symbol,
	input  dp_cmd_t     cmd,
	output dp_stat_t    stat,
	input  logic        out_ready,
	output logic        out_valid,
	output result_t     out_data
);

	localparam int TW = TIME_WIDTH;

	// Configuration registers.
	logic [1:0]  deck_q;
	logic [15:0] short_q;
	logic [15:0] long_q;
	logic [15:0] thr_q;

	// Held input beat.
	logic [1:0]    func_q;
	logic [TW-1:0] now_q;
	logic [1:0]    pv_q;
	logic          sym_q;

	// Deck state.
	logic          motor_on_q;
	logic          pulse_seen_q;
	logic [TW-1:0] start_q;
	logic [TW-1:0] elapsed_q;
	sym_t          cur_sym_q;
	logic          rec_level_q;
	logic [TW-1:0] rise_q;
	logic [TW-1:0] pos_q;

	result_t res_q;
	result_t out_q;
	logic    out_valid_q;

	logic fifo_push;
	logic fifo_empty;
	logic fifo_full;
	logic fifo_rd;

	logic          motor_nx;
	logic          pulse_nx;
	logic          turn_on;
	logic          level_eff;
	logic          rec_act;
	logic          rec_rise;
	logic          rec_fall;
	logic [TW-1:0] pulse_width;
	logic          rec_one;
	logic [TW-1:0] period;
	logic [TW-1:0] bit_end;
	logic [TW-1:0] in_bit;
	logic          tape_high;
	result_t       exec_res;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deck_q  <= DECK_STOP;
			short_q <= SHORT_PERIOD_RST;
			long_q  <= LONG_PERIOD_RST;
			thr_q   <= THRESHOLD_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_DECK_MODE: deck_q  <= cfg_wdata[1:0];
				REG_SHORT:     short_q <= cfg_wdata;
				REG_LONG:      long_q  <= cfg_wdata;
				REG_THRESHOLD: thr_q   <= cfg_wdata;
				default:       deck_q  <= deck_q;
			endcase
		end
	end

	// Input beat capture.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q <= func;
			now_q  <= TW'(now);
			pv_q   <= port_value[1:0];
			sym_q  <= tape_symbol;
		end
	end

	// Motor toggle on each release of the motor bit while the deck is not stopped.
	always_comb begin
		motor_nx = motor_on_q;
		pulse_nx = pulse_seen_q;
		turn_on  = 1'b0;
		if (deck_q != DECK_STOP) begin
			if (pv_q[PORT_MOTOR_BIT]) begin
				pulse_nx = 1'b1;
			end else if (pulse_seen_q) begin
				pulse_nx = 1'b0;
				motor_nx = !motor_on_q;
				turn_on  = !motor_on_q;
			end
		end
	end

	// Record edge detection and pulse width decision.
	assign level_eff   = turn_on ? 1'b0 : rec_level_q;
	assign rec_act     = (deck_q == DECK_RECORD) && motor_nx;
	assign rec_rise    = rec_act && !level_eff && pv_q[PORT_REC_BIT];
	assign rec_fall    = rec_act && level_eff && !pv_q[PORT_REC_BIT];
	assign pulse_width = now_q - rise_q;
	assign rec_one     = !(pulse_width < TW'(thr_q));

	// Result of the first execution step.
	always_comb begin
		exec_res = '0;
		case (func_q)
			FUNC_WRITE: begin
				exec_res.rec_valid = rec_fall;
				exec_res.rec_bit   = rec_fall && rec_one;
			end
			FUNC_READ: begin
				exec_res.read_valid = 1'b1;
				exec_res.read_data  = READ_BASE | (motor_on_q ? 8'h00 : READ_MOTOR_OFF);
			end
			FUNC_PUSH: begin
				exec_res.push_dropped = fifo_full;
			end
			default: begin
				exec_res = '0;
			end
		endcase
	end

	assign fifo_push = cmd.exec && (func_q == FUNC_PUSH) && !fifo_full;

	// Playback: length of the current symbol and the position within it.
	always_comb begin
		case (cur_sym_q)
			SYM_ZERO: period = TW'(short_q);
			SYM_ONE:  period = TW'(long_q);
			default:  period = '0;
		endcase
	end

	assign bit_end   = elapsed_q + period;
	assign in_bit    = pos_q - elapsed_q;
	assign tape_high = ((cur_sym_q == SYM_ZERO) || (cur_sym_q == SYM_ONE)) &&
		(in_bit < (period >> 1));

	// Deck, record and playback state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			motor_on_q   <= 1'b0;
			pulse_seen_q <= 1'b0;
			start_q      <= '0;
			elapsed_q    <= '0;
			cur_sym_q    <= SYM_NONE;
			rec_level_q  <= 1'b0;
			rise_q       <= '0;
		end else begin
			if (cmd.exec && (func_q == FUNC_WRITE)) begin
				motor_on_q   <= motor_nx;
				pulse_seen_q <= pulse_nx;
				if (turn_on) begin
					start_q   <= now_q;
					cur_sym_q <= SYM_NONE;
					elapsed_q <= '0;
				end
				if (rec_rise) begin
					rise_q <= now_q;
				end else if (turn_on) begin
					rise_q <= '0;
				end
				if (rec_act) begin
					rec_level_q <= pv_q[PORT_REC_BIT];
				end else if (turn_on) begin
					rec_level_q <= 1'b0;
				end
			end
			if (cmd.check && stat.more) begin
				elapsed_q <= bit_end;
				if (fifo_empty) begin
					cur_sym_q <= SYM_END;
				end
			end
			if (cmd.pop) begin
				cur_sym_q <= fifo_rd ? SYM_ONE : SYM_ZERO;
			end
		end
	end

	// Tape position of a read and the staged result.
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			pos_q <= now_q - start_q;
			res_q <= exec_res;
		end else if (cmd.level) begin
			res_q.read_data <= READ_BASE | (tape_high ? READ_TAPE_HIGH : 8'h00);
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q <= res_q;
		end
	end

	cppc_fifo #(
		.DEPTH(TAPE_FIFO_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (fifo_push),
		.push_data(sym_q),
		.pop      (cmd.pop),
		.empty    (fifo_empty),
		.full     (fifo_full),
		.rd_data  (fifo_rd)
	);

	// Status to the controller.
	assign stat.tape_read  = (func_q == FUNC_READ) && (deck_q == DECK_PLAY) && motor_on_q;
	assign stat.more       = !(pos_q < bit_end);
	assign stat.fifo_empty = fifo_empty;
	assign stat.out_free   = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// File: hdl/cppc_ctrl.sv
// Controller of the cassette port pulse codec: sequences one beat through the datapath.
// Depends on cppc_pkg.
`timescale 1ns / 1ps

module cppc_ctrl
	import cppc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_EXEC  = 3'd1;
	localparam logic [2:0] ST_CHECK = 3'd2;
	localparam logic [2:0] ST_POP   = 3'd3;
	localparam logic [2:0] ST_LEVEL = 3'd4;
	localparam logic [2:0] ST_EMIT  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_nx;

	assign in_ready = (state_q == ST_IDLE);

	// Next state and commands.
	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.capture = in_valid;
				if (in_valid) begin
					state_nx = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_nx = stat.tape_read ? ST_CHECK : ST_EMIT;
			end
			ST_CHECK: begin
				cmd.check = 1'b1;
				if (stat.more && !stat.fifo_empty) begin
					state_nx = ST_POP;
				end else begin
					state_nx = ST_LEVEL;
				end
			end
			ST_POP: begin
				cmd.pop  = 1'b1;
				state_nx = ST_CHECK;
			end
			ST_LEVEL: begin
				cmd.level = 1'b1;
				state_nx  = ST_EMIT;
			end
			ST_EMIT: begin
				cmd.load_out = stat.out_free;
				if (stat.out_free) begin
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

endmodule
